[sv/cksq_pkg.sv]
package cksq_pkg;

    // Register file geometry
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Command bytes
    localparam logic [7:0] CMD_NONE    = 8'h00;
    localparam logic [7:0] CMD_CONNECT = 8'h80;
    localparam logic [7:0] CMD_RESET   = 8'h40;

    // Phase codes as shown on the result
    localparam logic [1:0] PH_INIT       = 2'd0;
    localparam logic [1:0] PH_CLEAR      = 2'd1;
    localparam logic [1:0] PH_CONNECTING = 2'd2;
    localparam logic [1:0] PH_CONNECTED  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [23:0] KEEPALIVE_RST = 24'd8192;
    localparam logic [23:0] QUICK_RST     = 24'd1024;
    localparam logic [7:0]  CLEAR_RST     = 8'd4;
    localparam logic [7:0]  CONNECT_RST   = 8'd30;

    localparam logic [7:0] RETRY_MAX = 8'hFF;

    typedef enum logic [1:0] {
        REG_KEEPALIVE = 2'd0,
        REG_QUICK     = 2'd1,
        REG_CLEAR     = 2'd2,
        REG_CONNECT   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_STATUS = 2'd1,
        MODE_POLL   = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        ST_INIT       = 4'b0001,
        ST_CLEAR      = 4'b0010,
        ST_CONNECTING = 4'b0100,
        ST_CONNECTED  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [23:0] keepalive_period;
        logic [23:0] quick_delay;
        logic [7:0]  clear_tries;
        logic [7:0]  connect_tries;
    } t_cfg;

    // Map the one-hot state to its external phase code
    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        case (ph)
            ST_INIT:       code = PH_INIT;
            ST_CLEAR:      code = PH_CLEAR;
            ST_CONNECTING: code = PH_CONNECTING;
            ST_CONNECTED:  code = PH_CONNECTED;
            default:       code = PH_INIT;
        endcase
        return code;
    endfunction

endpackage

[sv/contactor_keepalive_sequencer.sv]
// Contactor keepalive sequencer. Takes one item per clock (tick, status message or
// send poll) and returns exactly one result item for each in the cycle after its
// acceptance. The whole state update is combinational compare-and-add logic, so the
// block sustains one item per cycle; o_ready drops only while a result sits in the
// output register and i_ready is low. Configuration sits on an APB port at byte
// addresses 0, 4, 8, 12 (keepalive period, quick delay, clear tries, connect
// tries). Write it only with no item in flight; the block does not enforce this.
module contactor_keepalive_sequencer import cksq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [31:0]       i_tick_time,
    input  logic [7:0]        i_fault_byte,
    input  logic [7:0]        i_pending_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_send_now,
    output logic [7:0]        o_command_byte,
    output logic [1:0]        o_phase,
    output logic              o_trap
);

    t_cfg cfg;

    cksq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_phase      r_phase, n_phase;
    logic [31:0] r_deadline, n_deadline;
    logic [7:0]  r_retry, n_retry;
    logic        r_pend, n_pend;
    logic [7:0]  r_cmd, n_cmd;
    logic        r_out_valid;
    logic        r_send, r_trap;
    logic [7:0]  r_out_cmd;
    logic [1:0]  r_out_phase;

    logic        accept;
    logic        send, trap;
    logic [7:0]  retry_inc;
    logic [31:0] dl_diff;
    logic        not_due;
    logic [31:0] dl_period, dl_quick;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign retry_inc = (r_retry == RETRY_MAX) ? r_retry : r_retry + 8'd1;
    assign dl_diff   = r_deadline - i_tick_time;
    assign not_due   = (dl_diff != 32'd0) && !dl_diff[31];
    assign dl_period = i_tick_time + {8'd0, cfg.keepalive_period};
    assign dl_quick  = i_tick_time + {8'd0, cfg.quick_delay};

    // Next state for the item at the input
    always_comb begin
        n_phase    = r_phase;
        n_deadline = r_deadline;
        n_retry    = r_retry;
        n_pend     = r_pend;
        n_cmd      = r_cmd;
        send       = 1'b0;
        trap       = 1'b0;
        case (t_mode'(i_mode))
            MODE_TICK: begin
                if (r_phase == ST_INIT) begin
                    n_deadline = dl_period;
                    n_cmd      = CMD_RESET;
                    n_retry    = 8'd0;
                    n_pend     = 1'b1;
                    n_phase    = ST_CLEAR;
                end else if (!not_due) begin
                    n_deadline = dl_period;
                    n_pend     = 1'b1;
                end
            end
            MODE_STATUS: begin
                case (r_phase)
                    ST_CLEAR: begin
                        if ((i_fault_byte != 8'd0) && (retry_inc < cfg.clear_tries)) begin
                            n_retry = retry_inc;
                        end else begin
                            n_retry = 8'd0;
                            n_cmd   = CMD_CONNECT;
                            n_phase = ST_CONNECTING;
                        end
                    end
                    ST_CONNECTING: begin
                        if (i_pending_byte != 8'd0) begin
                            n_retry = retry_inc;
                            if (retry_inc >= cfg.connect_tries) begin
                                n_phase = ST_INIT;
                            end
                        end else begin
                            n_phase = ST_CONNECTED;
                        end
                    end
                    ST_INIT: begin
                        trap = 1'b1;
                    end
                    default: ;
                endcase
                n_deadline = dl_quick;
            end
            MODE_POLL: begin
                if (r_pend) begin
                    n_pend = 1'b0;
                    send   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Advance sequencer state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ST_INIT;
            r_deadline <= 32'd0;
            r_retry    <= 8'd0;
            r_pend     <= 1'b0;
            r_cmd      <= CMD_NONE;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_deadline <= n_deadline;
            r_retry    <= n_retry;
            r_pend     <= n_pend;
            r_cmd      <= n_cmd;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_send      <= send;
            r_trap      <= trap;
            r_out_cmd   <= n_cmd;
            r_out_phase <= phase_code(n_phase);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_send_now     = r_send;
    assign o_trap         = r_trap;
    assign o_command_byte = r_out_cmd;
    assign o_phase        = r_out_phase;

endmodule

[sv/cksq_regs.sv]
module cksq_regs import cksq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keepalive_period <= KEEPALIVE_RST;
            r_cfg.quick_delay      <= QUICK_RST;
            r_cfg.clear_tries      <= CLEAR_RST;
            r_cfg.connect_tries    <= CONNECT_RST;
        end else if (wr_en) begin
            case (idx)
                REG_KEEPALIVE: r_cfg.keepalive_period <= pwdata[23:0];
                REG_QUICK:     r_cfg.quick_delay      <= pwdata[23:0];
                REG_CLEAR:     r_cfg.clear_tries      <= pwdata[7:0];
                REG_CONNECT:   r_cfg.connect_tries    <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    // Read back, zero extended
    always_comb begin
        case (idx)
            REG_KEEPALIVE: prdata = {8'd0, r_cfg.keepalive_period};
            REG_QUICK:     prdata = {8'd0, r_cfg.quick_delay};
            REG_CLEAR:     prdata = {24'd0, r_cfg.clear_tries};
            REG_CONNECT:   prdata = {24'd0, r_cfg.connect_tries};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[sv/cksq_checker.sv]
module cksq_checker import cksq_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_send_now,
    input logic [7:0] o_command_byte,
    input logic [1:0] o_phase,
    input logic       o_trap
);

    // Drop any pending result on reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A trap result leaves the sequencer in init wait
    a_trap_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_trap) |-> (o_phase == PH_INIT))
        else $error("trap outside init wait");

    // Past init the command is connect or reset fault
    a_cmd_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_phase != PH_INIT)) |->
        ((o_command_byte == CMD_CONNECT) || (o_command_byte == CMD_RESET)))
        else $error("unexpected command byte");

    // A keepalive send always carries a command
    a_send_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_send_now) |-> (o_command_byte != CMD_NONE))
        else $error("send without command");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_command_byte) && $stable(o_phase)))
        else $error("stalled result changed");

endmodule

bind contactor_keepalive_sequencer cksq_checker u_cksq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_send_now     (o_send_now),
    .o_command_byte (o_command_byte),
    .o_phase        (o_phase),
    .o_trap         (o_trap)
);
